// File: hdl/escc_pkg.sv
// ----------------------------------------------------------------------------
// escc_pkg: shared types, constants and microprogram
// Calendar constants, control word layout, microcode table and request/result
// structures for the epoch seconds calendar converter.
// ----------------------------------------------------------------------------
package escc_pkg;

  localparam int unsigned PC_W         = 5;
  localparam logic [7:0]  MAX_YEAR_OFS = 8'd136;
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam logic [4:0]  DIV_STEPS_T  = 5'd16;
  localparam logic [4:0]  DIV_STEPS_M  = 5'd14;
  localparam logic [4:0]  DIV_STEPS_H  = 5'd11;
  localparam logic [4:0]  DIV_STEPS_D  = 5'd8;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // datapath micro-operations
  localparam logic [3:0] U_NOP    = 4'd0;
  localparam logic [3:0] U_LOAD   = 4'd1;
  localparam logic [3:0] U_DIV    = 4'd2;
  localparam logic [3:0] U_SEC    = 4'd3;
  localparam logic [3:0] U_MIN    = 4'd4;
  localparam logic [3:0] U_HOUR   = 4'd5;
  localparam logic [3:0] U_YEAR   = 4'd6;
  localparam logic [3:0] U_WALK   = 4'd7;
  localparam logic [3:0] U_CHECK  = 4'd8;
  localparam logic [3:0] U_MADD   = 4'd9;
  localparam logic [3:0] U_MUL24  = 4'd10;
  localparam logic [3:0] U_MUL60M = 4'd11;
  localparam logic [3:0] U_MUL60S = 4'd12;
  localparam logic [3:0] U_OVF    = 4'd13;

  // divisor select
  localparam logic [1:0] D_60  = 2'd0;
  localparam logic [1:0] D_24  = 2'd1;
  localparam logic [1:0] D_365 = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEXT   = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_OP1    = 3'd2;
  localparam logic [2:0] C_LOOP   = 3'd3;
  localparam logic [2:0] C_WALK   = 3'd4;
  localparam logic [2:0] C_BAD    = 3'd5;
  localparam logic [2:0] C_MADD   = 3'd6;

  // program addresses
  localparam logic [PC_W-1:0] P_START = 5'd0;
  localparam logic [PC_W-1:0] P_DIVS  = 5'd1;
  localparam logic [PC_W-1:0] P_SEC   = 5'd2;
  localparam logic [PC_W-1:0] P_DIVM  = 5'd3;
  localparam logic [PC_W-1:0] P_MIN   = 5'd4;
  localparam logic [PC_W-1:0] P_DIVH  = 5'd5;
  localparam logic [PC_W-1:0] P_HOUR  = 5'd6;
  localparam logic [PC_W-1:0] P_DIVD  = 5'd7;
  localparam logic [PC_W-1:0] P_YEAR  = 5'd8;
  localparam logic [PC_W-1:0] P_WALK  = 5'd9;
  localparam logic [PC_W-1:0] P_WEND  = 5'd10;
  localparam logic [PC_W-1:0] P_CAL   = 5'd11;
  localparam logic [PC_W-1:0] P_MADD  = 5'd12;
  localparam logic [PC_W-1:0] P_MUL24 = 5'd13;
  localparam logic [PC_W-1:0] P_MULM  = 5'd14;
  localparam logic [PC_W-1:0] P_MULS  = 5'd15;
  localparam logic [PC_W-1:0] P_OVF   = 5'd16;
  localparam logic [PC_W-1:0] P_FIN   = 5'd17;

  typedef struct packed {
    logic [3:0]      uop;
    logic [1:0]      divsel;
    logic [2:0]      cond;
    logic [PC_W-1:0] jump;
    logic            fin;
  } ucw_t;

  typedef struct packed {
    logic op1;
    logic loop_more;
    logic walk_ok;
    logic madd_ok;
    logic bad;
  } flags_t;

  typedef struct packed {
    logic        op;
    logic [31:0] epoch_seconds;
    logic [7:0]  in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } req_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  status;
  } res_t;

  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'd2);
  endfunction

  // days in month m of year offset y, 0 for a month code outside 1..12
  function automatic logic [4:0] month_days(input logic [7:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:    d = is_leap(y) ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic ucw_t cw(input logic [3:0] uop, input logic [1:0] divsel,
                              input logic [2:0] cond, input logic [PC_W-1:0] jump,
                              input logic fin);
    ucw_t w;
    w.uop    = uop;
    w.divsel = divsel;
    w.cond   = cond;
    w.jump   = jump;
    w.fin    = fin;
    return w;
  endfunction

  function automatic ucw_t ucode(input logic [PC_W-1:0] addr);
    ucw_t w;
    case (addr)
      P_START: w = cw(U_LOAD,   D_60,  C_OP1,    P_CAL,   1'b0);
      P_DIVS:  w = cw(U_DIV,    D_60,  C_LOOP,   P_DIVS,  1'b0);
      P_SEC:   w = cw(U_SEC,    D_60,  C_NEXT,   P_START, 1'b0);
      P_DIVM:  w = cw(U_DIV,    D_60,  C_LOOP,   P_DIVM,  1'b0);
      P_MIN:   w = cw(U_MIN,    D_60,  C_NEXT,   P_START, 1'b0);
      P_DIVH:  w = cw(U_DIV,    D_24,  C_LOOP,   P_DIVH,  1'b0);
      P_HOUR:  w = cw(U_HOUR,   D_60,  C_NEXT,   P_START, 1'b0);
      P_DIVD:  w = cw(U_DIV,    D_365, C_LOOP,   P_DIVD,  1'b0);
      P_YEAR:  w = cw(U_YEAR,   D_60,  C_NEXT,   P_START, 1'b0);
      P_WALK:  w = cw(U_WALK,   D_60,  C_WALK,   P_WALK,  1'b0);
      P_WEND:  w = cw(U_NOP,    D_60,  C_ALWAYS, P_FIN,   1'b0);
      P_CAL:   w = cw(U_CHECK,  D_60,  C_BAD,    P_FIN,   1'b0);
      P_MADD:  w = cw(U_MADD,   D_60,  C_MADD,   P_MADD,  1'b0);
      P_MUL24: w = cw(U_MUL24,  D_60,  C_NEXT,   P_START, 1'b0);
      P_MULM:  w = cw(U_MUL60M, D_60,  C_NEXT,   P_START, 1'b0);
      P_MULS:  w = cw(U_MUL60S, D_60,  C_NEXT,   P_START, 1'b0);
      P_OVF:   w = cw(U_OVF,    D_60,  C_NEXT,   P_START, 1'b0);
      P_FIN:   w = cw(U_NOP,    D_60,  C_NEXT,   P_START, 1'b1);
      default: w = cw(U_NOP,    D_60,  C_NEXT,   P_START, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/escc_if.sv
// ----------------------------------------------------------------------------
// escc_if: request and result channels
// Valid/ready channels carrying conversion requests and conversion results.
// ----------------------------------------------------------------------------
interface escc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] epoch_seconds;
  logic [7:0]  in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;

  modport source (
    output valid, op, epoch_seconds, in_year, in_month, in_day, in_hour,
           in_minute, in_second,
    input  ready
  );
  modport sink (
    input  valid, op, epoch_seconds, in_year, in_month, in_day, in_hour,
           in_minute, in_second,
    output ready
  );
endinterface

interface escc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_seconds;
  logic [7:0]  res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic [4:0]  res_hour;
  logic [5:0]  res_minute;
  logic [5:0]  res_second;
  logic [1:0]  status;

  modport source (
    output valid, res_seconds, res_year, res_month, res_day, res_hour,
           res_minute, res_second, status,
    input  ready
  );
  modport sink (
    input  valid, res_seconds, res_year, res_month, res_day, res_hour,
           res_minute, res_second, status,
    output ready
  );
endinterface

// File: hdl/epoch_seconds_calendar_converter.sv
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_converter: seconds since 1970 <-> calendar fields
// Top level: request capture, microcode sequencer, datapath, result register.
// ----------------------------------------------------------------------------
// One item is converted at a time. Op 0 (seconds to calendar) runs four
// radix-4 divisions by 60, 60, 24 and 365 through one shared divider (49
// steps) and a month walk of one step per month passed. Op 1 (calendar to
// seconds) sums one step per month, or goes straight to the result when a
// field is out of range. A new item is accepted as soon as the previous one
// has finished, even while its result still waits in the output register.
module epoch_seconds_calendar_converter (
  input logic       clk,
  input logic       rst_n,
  escc_in_if.sink   in_ch,
  escc_out_if.source out_ch
);

  escc_pkg::req_t   req_r, req_nxt;
  escc_pkg::res_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  escc_pkg::ucw_t   ctl;
  escc_pkg::flags_t flags;
  escc_pkg::res_t   res;
  logic             busy, done, hold, start;

  assign in_ch.ready = !busy;
  assign start       = in_ch.valid && !busy;
  assign hold        = out_valid_r && !out_ch.ready;

  always_comb begin
    req_nxt = req_r;
    if (start) begin
      req_nxt.op            = in_ch.op;
      req_nxt.epoch_seconds = in_ch.epoch_seconds;
      req_nxt.in_year       = in_ch.in_year;
      req_nxt.in_month      = in_ch.in_month;
      req_nxt.in_day        = in_ch.in_day;
      req_nxt.in_hour       = in_ch.in_hour;
      req_nxt.in_minute     = in_ch.in_minute;
      req_nxt.in_second     = in_ch.in_second;
    end
  end

  escc_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  escc_dpath u_dp (
    .clk   (clk),
    .req   (req_r),
    .ctl   (ctl),
    .flags (flags),
    .res   (res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.res_seconds = out_r.seconds;
  assign out_ch.res_year    = out_r.year;
  assign out_ch.res_month   = out_r.month;
  assign out_ch.res_day     = out_r.day;
  assign out_ch.res_hour    = out_r.hour;
  assign out_ch.res_minute  = out_r.minute;
  assign out_ch.res_second  = out_r.second;
  assign out_ch.status      = out_r.status;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("accepted item did not start the sequencer");

  a_done_room: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !hold)
    else $error("result written over a waiting result");

endmodule

// File: hdl/escc_useq.sv
// ----------------------------------------------------------------------------
// escc_useq: microcode sequencer
// Step counter over the control store with conditional jumps; issues one
// control word per cycle while in work; stalls at the end if a result waits.
// ----------------------------------------------------------------------------
module escc_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            hold,
  input  escc_pkg::flags_t flags,
  output escc_pkg::ucw_t  ctl,
  output logic            busy,
  output logic            done
);

  logic [escc_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      busy_r, busy_nxt;
  escc_pkg::ucw_t            word;
  logic                      take;

  assign word = escc_pkg::ucode(pc_r);

  always_comb begin
    case (word.cond)
      escc_pkg::C_NEXT:   take = 1'b0;
      escc_pkg::C_ALWAYS: take = 1'b1;
      escc_pkg::C_OP1:    take = flags.op1;
      escc_pkg::C_LOOP:   take = flags.loop_more;
      escc_pkg::C_WALK:   take = flags.walk_ok;
      escc_pkg::C_BAD:    take = flags.bad;
      escc_pkg::C_MADD:   take = flags.madd_ok;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    if (busy_r) begin
      if (word.fin) begin
        if (!hold) begin
          done     = 1'b1;
          busy_nxt = 1'b0;
          pc_nxt   = escc_pkg::P_START;
        end
      end else if (take) begin
        pc_nxt = word.jump;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = escc_pkg::P_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= escc_pkg::P_START;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign ctl  = busy_r ? word
                       : escc_pkg::cw(escc_pkg::U_NOP, escc_pkg::D_60, escc_pkg::C_NEXT,
                                      escc_pkg::P_START, 1'b0);

  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pc_r == escc_pkg::P_START)
    else $error("sequencer idle away from program start");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r)
    else $error("sequencer still busy after finishing");

endmodule

// File: hdl/escc_dpath.sv
// ----------------------------------------------------------------------------
// escc_dpath: conversion datapath
// Radix-4 divider by a selected constant, calendar registers, month walk and
// shift-add scaling, steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module escc_dpath (
  input  logic             clk,
  input  escc_pkg::req_t   req,
  input  escc_pkg::ucw_t   ctl,
  output escc_pkg::flags_t flags,
  output escc_pkg::res_t   res
);

  logic [31:0] acc_r, acc_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [32:0] tot_r, tot_nxt;
  logic [1:0]  st_r, st_nxt;

  logic [8:0]  dvs;
  logic [10:0] sh, d1, d2, d3, sub;
  logic [1:0]  qd;
  logic [4:0]  md_cur, md_in;
  logic [8:0]  leap_before;
  logic [8:0]  q9;
  logic        bad;
  logic [16:0] y365;

  // divisor and one radix-4 step
  always_comb begin
    case (ctl.divsel)
      escc_pkg::D_60:  dvs = 9'd60;
      escc_pkg::D_24:  dvs = 9'd24;
      escc_pkg::D_365: dvs = escc_pkg::DAYS_PER_YR;
      default:         dvs = 9'd60;
    endcase
    sh = {rem_r, acc_r[31:30]};
    d1 = {2'b00, dvs};
    d2 = {1'b0, dvs, 1'b0};
    d3 = d1 + d2;
    if (sh >= d3) begin
      qd  = 2'd3;
      sub = sh - d3;
    end else if (sh >= d2) begin
      qd  = 2'd2;
      sub = sh - d2;
    end else if (sh >= d1) begin
      qd  = 2'd1;
      sub = sh - d1;
    end else begin
      qd  = 2'd0;
      sub = sh;
    end
  end

  assign md_cur      = escc_pkg::month_days(y_r, m_r);
  assign md_in       = escc_pkg::month_days(req.in_year, req.in_month);
  assign q9          = {1'b0, acc_r[7:0]};
  assign leap_before = (q9 + 9'd1) >> 2;
  assign y365        = {9'b0, req.in_year} * 17'(escc_pkg::DAYS_PER_YR);

  assign bad = (req.in_year > escc_pkg::MAX_YEAR_OFS) || (req.in_month == 4'd0) ||
               (req.in_month > 4'd12) || (req.in_day == 5'd0) || (req.in_day > md_in) ||
               (req.in_hour > 5'd23) || (req.in_minute > 6'd59) || (req.in_second > 6'd59);

  assign flags.op1       = req.op;
  assign flags.loop_more = (cnt_r != 5'd1);
  assign flags.walk_ok   = (m_r < 4'd12) && (doy_r >= {4'b0, md_cur});
  assign flags.madd_ok   = (m_r < req.in_month);
  assign flags.bad       = bad;

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    doy_nxt  = doy_r;
    tot_nxt  = tot_r;
    st_nxt   = st_r;
    case (ctl.uop)
      escc_pkg::U_NOP: begin
      end
      escc_pkg::U_LOAD: begin
        acc_nxt = req.epoch_seconds;
        rem_nxt = 9'd0;
        cnt_nxt = escc_pkg::DIV_STEPS_T;
        st_nxt  = escc_pkg::ST_OK;
      end
      escc_pkg::U_DIV: begin
        acc_nxt = {acc_r[29:0], qd};
        rem_nxt = sub[8:0];
        cnt_nxt = cnt_r - 5'd1;
      end
      escc_pkg::U_SEC: begin
        sec_nxt = rem_r[5:0];
        acc_nxt = acc_r << (32 - 2 * escc_pkg::DIV_STEPS_M);
        rem_nxt = 9'd0;
        cnt_nxt = escc_pkg::DIV_STEPS_M;
      end
      escc_pkg::U_MIN: begin
        min_nxt = rem_r[5:0];
        acc_nxt = acc_r << (32 - 2 * escc_pkg::DIV_STEPS_H);
        rem_nxt = 9'd0;
        cnt_nxt = escc_pkg::DIV_STEPS_H;
      end
      escc_pkg::U_HOUR: begin
        hour_nxt = rem_r[4:0];
        acc_nxt  = acc_r << (32 - 2 * escc_pkg::DIV_STEPS_D);
        rem_nxt  = 9'd0;
        cnt_nxt  = escc_pkg::DIV_STEPS_D;
      end
      escc_pkg::U_YEAR: begin
        // year estimate from days / 365, pulled back one near year end
        m_nxt = 4'd1;
        if (leap_before > rem_r) begin
          y_nxt   = acc_r[7:0] - 8'd1;
          doy_nxt = rem_r + escc_pkg::DAYS_PER_YR - (q9 >> 2);
        end else begin
          y_nxt   = acc_r[7:0];
          doy_nxt = rem_r - leap_before;
        end
      end
      escc_pkg::U_WALK: begin
        if (flags.walk_ok) begin
          doy_nxt = doy_r - {4'b0, md_cur};
          m_nxt   = m_r + 4'd1;
        end
      end
      escc_pkg::U_CHECK: begin
        y_nxt   = req.in_year;
        m_nxt   = 4'd1;
        st_nxt  = bad ? escc_pkg::ST_RANGE : escc_pkg::ST_OK;
        tot_nxt = 33'(y365) + 33'((9'(req.in_year) + 9'd1) >> 2) + 33'(req.in_day) - 33'd1;
      end
      escc_pkg::U_MADD: begin
        if (flags.madd_ok) begin
          tot_nxt = tot_r + 33'(md_cur);
          m_nxt   = m_r + 4'd1;
        end
      end
      escc_pkg::U_MUL24: begin
        tot_nxt = (tot_r << 4) + (tot_r << 3) + 33'(req.in_hour);
      end
      escc_pkg::U_MUL60M: begin
        tot_nxt = (tot_r << 6) - (tot_r << 2) + 33'(req.in_minute);
      end
      escc_pkg::U_MUL60S: begin
        tot_nxt = (tot_r << 6) - (tot_r << 2) + 33'(req.in_second);
      end
      escc_pkg::U_OVF: begin
        if (tot_r[32]) begin
          st_nxt = escc_pkg::ST_OVF;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    doy_r  <= doy_nxt;
    tot_r  <= tot_nxt;
    st_r   <= st_nxt;
  end

  always_comb begin
    res = '0;
    if (req.op) begin
      res.status = st_r;
      if (st_r == escc_pkg::ST_OK) begin
        res.seconds = tot_r[31:0];
      end
    end else begin
      res.year   = y_r;
      res.month  = m_r;
      res.day    = doy_r[4:0] + 5'd1;
      res.hour   = hour_r;
      res.minute = min_r;
      res.second = sec_r;
      res.status = escc_pkg::ST_OK;
    end
  end

  a_div_count: assert property (@(posedge clk)
    ctl.uop == escc_pkg::U_DIV |-> cnt_r != 5'd0)
    else $error("divide step with no steps left");

  a_doy_range: assert property (@(posedge clk)
    ctl.uop == escc_pkg::U_YEAR |=> doy_r < 9'd366)
    else $error("day of year out of range after year fix");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the epoch seconds calendar converter
// Sends conversions in both directions through the valid/ready request
// channel: directed corners (epoch limits, leap days, year ends, overflow and
// every out-of-range calendar field), then random traffic under changing
// idle and stall rates, a long result hold-off and a drain-and-restart.
// Every result is compared field by field against a calendar model kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import escc_pkg::*;

  localparam logic OP_TO_CALENDAR = 1'b0;
  localparam logic OP_TO_SECONDS  = 1'b1;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;

  escc_in_if  in_ch ();
  escc_out_if out_ch ();

  epoch_seconds_calendar_converter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  res_t pending_conversions [$];
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // calendar model
  function automatic bit leap_year(int unsigned y);
    return ((y + 2) % 4) == 0;
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned n;
    if (m > 12) return 0;
    n = MONTH_LEN[m];
    if (m == 2 && leap_year(y)) n++;
    return n;
  endfunction

  function automatic int unsigned days_to_year(int unsigned y);
    return y * 365 + (y + 1) / 4;
  endfunction

  function automatic int unsigned days_to_month(int unsigned y, int unsigned m);
    int unsigned d;
    d = days_to_year(y);
    for (int unsigned i = 1; i < m; i++) d += month_length(y, i);
    return d;
  endfunction

  function automatic res_t convert_expected(req_t rq);
    res_t            r;
    int unsigned     t;
    int unsigned     days;
    int unsigned     y;
    int unsigned     doy;
    int unsigned     m;
    longint unsigned total;
    r = '0;
    if (rq.op == OP_TO_CALENDAR) begin
      t = rq.epoch_seconds;
      r.second = 6'(t % 60);
      t = t / 60;
      r.minute = 6'(t % 60);
      t = t / 60;
      r.hour = 5'(t % 24);
      days = t / 24;
      y = days / 365;
      if (days_to_year(y) > days) y--;
      doy = days - days_to_year(y);
      m = 1;
      while (m < 12 && doy >= month_length(y, m)) begin
        doy -= month_length(y, m);
        m++;
      end
      r.year   = 8'(y);
      r.month  = 4'(m);
      r.day    = 5'(doy + 1);
      r.status = ST_OK;
    end else if (rq.in_year > MAX_YEAR_OFS || rq.in_month < 1 || rq.in_month > 12 ||
                 rq.in_day == 0 || rq.in_day > month_length(rq.in_year, rq.in_month) ||
                 rq.in_hour >= 24 || rq.in_minute >= 60 || rq.in_second >= 60) begin
      r.status = ST_RANGE;
    end else begin
      total = longint'(days_to_month(rq.in_year, rq.in_month)) + rq.in_day - 1;
      total = ((total * 24 + rq.in_hour) * 60 + rq.in_minute) * 60 + rq.in_second;
      if (total > 64'hFFFF_FFFF) begin
        r.status = ST_OVF;
      end else begin
        r.seconds = total[31:0];
        r.status  = ST_OK;
      end
    end
    return r;
  endfunction

  // stimulus helpers
  function automatic req_t noise_request();
    req_t r;
    r.op            = 1'($urandom_range(1));
    r.epoch_seconds = $urandom;
    r.in_year       = 8'($urandom);
    r.in_month      = 4'($urandom);
    r.in_day        = 5'($urandom);
    r.in_hour       = 5'($urandom);
    r.in_minute     = 6'($urandom);
    r.in_second     = 6'($urandom);
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned sel;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    longint      near_secs;
    r = noise_request();
    sel = $urandom_range(99);
    if (sel < 55) begin
      r.op = OP_TO_CALENDAR;
      if ($urandom_range(1) == 1) begin
        // around a month start, year starts included
        y = $urandom_range(135);
        m = $urandom_range(1, 12);
        near_secs = longint'(days_to_month(y, m)) * SECS_PER_DAY +
                    $urandom_range(2 * SECS_PER_DAY - 1) - SECS_PER_DAY;
        r.epoch_seconds = near_secs[31:0];
      end
    end else begin
      r.op = OP_TO_SECONDS;
      if (sel < 90) begin
        y = ($urandom_range(5) == 0) ? MAX_YEAR_OFS : $urandom_range(MAX_YEAR_OFS);
        m = $urandom_range(1, 12);
        len = month_length(y, m);
        r.in_year   = 8'(y);
        r.in_month  = 4'(m);
        r.in_day    = 5'($urandom_range(1, len));
        r.in_hour   = 5'($urandom_range(23));
        r.in_minute = 6'($urandom_range(59));
        r.in_second = 6'($urandom_range(59));
        if (sel >= 78) begin
          case ($urandom_range(5))
            0: r.in_year  = 8'($urandom_range(137, 255));
            1: r.in_month = ($urandom_range(1) == 1) ? 4'd0 : 4'($urandom_range(13, 15));
            2: r.in_day   = (len == 31 || $urandom_range(1) == 1) ? 5'd0 :
                            5'($urandom_range(len + 1, 31));
            3: r.in_hour   = 5'($urandom_range(24, 31));
            4: r.in_minute = 6'($urandom_range(60, 63));
            default: r.in_second = 6'($urandom_range(60, 63));
          endcase
        end
      end
    end
    return r;
  endfunction

  task automatic send_conversion(input req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= rq.op;
    in_ch.epoch_seconds <= rq.epoch_seconds;
    in_ch.in_year       <= rq.in_year;
    in_ch.in_month      <= rq.in_month;
    in_ch.in_day        <= rq.in_day;
    in_ch.in_hour       <= rq.in_hour;
    in_ch.in_minute     <= rq.in_minute;
    in_ch.in_second     <= rq.in_second;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_conversions.push_back(convert_expected(rq));
  endtask

  task automatic send_split(input logic [31:0] secs);
    req_t rq;
    rq = noise_request();
    rq.op = OP_TO_CALENDAR;
    rq.epoch_seconds = secs;
    send_conversion(rq);
  endtask

  task automatic send_pack(input logic [7:0] y, input logic [3:0] mo, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    req_t rq;
    rq = noise_request();
    rq.op        = OP_TO_SECONDS;
    rq.in_year   = y;
    rq.in_month  = mo;
    rq.in_day    = d;
    rq.in_hour   = h;
    rq.in_minute = mi;
    rq.in_second = s;
    send_conversion(rq);
  endtask

  function automatic logic [31:0] midnight_of(int unsigned y, int unsigned m, int unsigned d);
    return (days_to_month(y, m) + d - 1) * SECS_PER_DAY;
  endfunction

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
  endtask

  // result checking
  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    res_t e;
    if (pending_conversions.size() == 0) begin
      $display("%0t unexpected result item: seconds %0h status %0d", $time,
               out_ch.res_seconds, out_ch.status);
      mismatch_cnt++;
    end else begin
      e = pending_conversions.pop_front();
      check_field("seconds", e.seconds, out_ch.res_seconds);
      check_field("year",    e.year,    out_ch.res_year);
      check_field("month",   e.month,   out_ch.res_month);
      check_field("day",     e.day,     out_ch.res_day);
      check_field("hour",    e.hour,    out_ch.res_hour);
      check_field("minute",  e.minute,  out_ch.res_minute);
      check_field("second",  e.second,  out_ch.res_second);
      check_field("status",  e.status,  out_ch.status);
    end
  endtask

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      if (hold_reqs != hold_seen) begin
        hold_seen    <= hold_reqs;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_conversions.size());
      $display("status: fail");
      $finish;
    end
  end

  // tests
  task automatic test_split_corners();
    send_split(32'd0);
    send_split(32'hFFFF_FFFF);
    send_split(SECS_PER_DAY - 1);
    send_split(SECS_PER_DAY);
    send_split(midnight_of(1, 1, 1) - 1);
    send_split(midnight_of(2, 2, 29) - 1);
    send_split(midnight_of(2, 2, 29));
    send_split(midnight_of(2, 3, 1));
    send_split(midnight_of(3, 1, 1) - 1);
    send_split(midnight_of(130, 2, 29) + 43210);
  endtask

  task automatic test_pack_corners();
    send_pack(8'd0,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
    send_pack(8'd136, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15);
    send_pack(8'd136, 4'd2,  5'd7,  5'd6,  6'd28, 6'd16);
    send_pack(8'd136, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_pack(8'd137, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
    send_pack(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_pack(8'd2,   4'd2,  5'd29, 5'd12, 6'd0,  6'd0);
    send_pack(8'd1,   4'd2,  5'd29, 5'd12, 6'd0,  6'd0);
    send_pack(8'd2,   4'd2,  5'd30, 5'd0,  6'd0,  6'd0);
    send_pack(8'd130, 4'd2,  5'd29, 5'd23, 6'd59, 6'd59);
    send_pack(8'd5,   4'd0,  5'd1,  5'd0,  6'd0,  6'd0);
    send_pack(8'd5,   4'd13, 5'd1,  5'd0,  6'd0,  6'd0);
    send_pack(8'd5,   4'd4,  5'd31, 5'd0,  6'd0,  6'd0);
    send_pack(8'd5,   4'd4,  5'd0,  5'd0,  6'd0,  6'd0);
    send_pack(8'd5,   4'd1,  5'd31, 5'd24, 6'd0,  6'd0);
    send_pack(8'd5,   4'd1,  5'd31, 5'd23, 6'd60, 6'd0);
    send_pack(8'd5,   4'd1,  5'd31, 5'd23, 6'd59, 6'd60);
  endtask

  task automatic test_random_traffic(input int count, input int src_idle, input int dst_stall);
    send_idle_pct = src_idle;
    stall_pct     = dst_stall;
    repeat (count) send_conversion(random_request());
  endtask

  // results held back long enough for the request side to back up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs    <= hold_reqs + 1;
    repeat (12) send_conversion(random_request());
  endtask

  task automatic test_restart_after_drain();
    send_idle_pct = 10;
    stall_pct     = 20;
    repeat (6) send_conversion(random_request());
    wait_all_results();
    repeat (6) send_conversion(random_request());
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_TO_CALENDAR;
    in_ch.epoch_seconds = '0;
    in_ch.in_year       = '0;
    in_ch.in_month      = '0;
    in_ch.in_day        = '0;
    in_ch.in_hour       = '0;
    in_ch.in_minute     = '0;
    in_ch.in_second     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    stall_pct     = 55;
    test_split_corners();
    test_pack_corners();
    test_random_traffic(430, 28, 55);
    test_random_traffic(430, 55, 28);
    test_random_traffic(430, 0, 0);
    test_output_backpressure();
    test_restart_after_drain();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/escc_pkg.sv
hdl/escc_if.sv
hdl/escc_useq.sv
hdl/escc_dpath.sv
hdl/epoch_seconds_calendar_converter.sv
verif/tb_top.sv
